// ===== rtl/kvse_pkg.sv =====
`timescale 1ns / 1ps

package kvse_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WHEEL_RADIUS      = 3'd0;
    localparam logic [2:0] CFG_PROCESS_NOISE     = 3'd1;
    localparam logic [2:0] CFG_MEASUREMENT_NOISE = 3'd2;
    localparam logic [2:0] CFG_REJECT_THRESHOLD  = 3'd3;
    localparam logic [2:0] CFG_REJECT_FACTOR     = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_WHEEL_RADIUS      = 16'd16646;
    localparam logic [31:0] RST_PROCESS_NOISE     = 32'd3277;
    localparam logic [31:0] RST_MEASUREMENT_NOISE = 32'd32768;
    localparam logic [31:0] RST_REJECT_THRESHOLD  = 32'd131072;
    localparam logic [7:0]  RST_REJECT_FACTOR     = 8'd50;

    // Filter state reset values.
    localparam logic [31:0] RST_ERROR_VARIANCE = 32'd65536;

    // Time base and fixed-point scaling.
    localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
    localparam logic [19:0] HALF_MICROS       = 20'd500000;
    localparam int          GAIN_BITS         = 24;
    localparam logic [24:0] GAIN_ONE          = 25'd1 << GAIN_BITS;
    localparam logic [57:0] GAIN_HALF         = 58'd1 << (GAIN_BITS - 1);
    localparam logic [40:0] MEAS_HALF         = 41'd4096;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DELTA,
        S_DIV_DELTA,
        S_PREDICT,
        S_MUL_MEAS,
        S_INNOV,
        S_REJECT,
        S_MUL_NOISE,
        S_GAIN,
        S_DIV_GAIN,
        S_CORR_START,
        S_MUL_CORR,
        S_SPEED,
        S_MUL_VAR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/kalman_vehicle_speed_estimator.sv =====
`timescale 1ns / 1ps

// Scalar Kalman filter for vehicle speed. One item is processed at a time: the
// input accepts a transfer only while the sequencer is idle, and each item gives
// exactly one result, held in an output register until it is taken, so the next
// item can be accepted while a result waits. An item with a zero time step goes
// from idle straight to the done state, which loads the output register once it is
// free. Any other item runs through a shared bit-serial shift-add multiplier (one
// multiplier bit per cycle, finishing early when the remaining bits are zero) used
// up to five times, and a shared restoring divider (one quotient bit per cycle)
// used for the time-base scaling and for the gain. The sequencer returns to idle
// as the result is loaded, and waits in the done state while an earlier result
// still occupies the output register.
// Configuration writes are always accepted and must be made only while the block
// is idle.

module kalman_vehicle_speed_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [23:0] front_left_speed, [47:24] front_right_speed, [71:48] accel_x,
    // [91:72] time_step, [95:92] zero
    input  logic [95:0] i_s_axis_tdata,
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] speed_estimate
    output logic [31:0] o_m_axis_tdata,
    // [0] wheels_rejected
    output logic        o_m_axis_tuser
);

    // Configuration registers.
    logic [15:0] r_wheel_radius;
    logic [31:0] r_process_noise;
    logic [31:0] r_meas_noise;
    logic [31:0] r_reject_thr;
    logic [7:0]  r_reject_factor;

    // Filter state.
    logic signed [31:0] r_speed_state, n_speed_state;
    logic        [31:0] r_error_var, n_error_var;

    // Sequencer and per-item values.
    kvse_pkg::t_state   r_state, n_state;
    logic signed [24:0] r_wheel_sum, n_wheel_sum;
    logic               r_ax_neg, n_ax_neg;
    logic signed [31:0] r_vp, n_vp;
    logic        [31:0] r_p, n_p;
    logic signed [28:0] r_meas, n_meas;
    logic signed [33:0] r_innov, n_innov;
    logic signed [33:0] r_corr, n_corr;
    logic               r_rej, n_rej;

    // Shift-add multiplier.
    logic [57:0] r_mul_acc, n_mul_acc;
    logic [57:0] r_mul_mc, n_mul_mc;
    logic [24:0] r_mul_mp, n_mul_mp;

    // Restoring divider.
    logic [55:0] r_div_rem, n_div_rem;
    logic [64:0] r_div_den, n_div_den;
    logic [24:0] r_div_q, n_div_q;
    logic [4:0]  r_div_cnt, n_div_cnt;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_out_speed, n_out_speed;
    logic               r_out_rej, n_out_rej;

    // Combinational helpers.
    logic signed [23:0] in_front_left;
    logic signed [23:0] in_front_right;
    logic signed [23:0] in_accel;
    logic        [19:0] in_time_step;
    logic               in_accept;
    logic        [23:0] accel_mag;
    logic        [24:0] wheel_mag;
    logic        [33:0] innov_mag;
    logic               mul_busy;
    logic               mul_run;
    logic        [57:0] mul_sum;
    logic               div_run;
    logic               div_ge;
    logic        [55:0] div_diff;
    logic signed [33:0] delta_mag;
    logic signed [33:0] delta;
    logic signed [34:0] pred;
    logic        [32:0] p_sum;
    logic        [40:0] meas_sum;
    logic signed [28:0] meas_mag;
    logic        [39:0] noise;
    logic        [40:0] den;
    logic        [57:0] corr_sum;
    logic signed [33:0] corr_mag;
    logic        [57:0] var_sum;

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] f_sat32(input logic signed [34:0] x);
        logic signed [34:0] lim_hi;
        logic signed [34:0] lim_lo;
        lim_hi = 35'sd2147483647;
        lim_lo = -35'sd2147483648;
        if (x > lim_hi) begin
            f_sat32 = 32'sh7FFFFFFF;
        end else if (x < lim_lo) begin
            f_sat32 = 32'sh80000000;
        end else begin
            f_sat32 = x[31:0];
        end
    endfunction

    // Unpack the input item.
    assign in_front_left  = i_s_axis_tdata[23:0];
    assign in_front_right = i_s_axis_tdata[47:24];
    assign in_accel       = i_s_axis_tdata[71:48];
    assign in_time_step   = i_s_axis_tdata[91:72];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == kvse_pkg::S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_speed;
    assign o_m_axis_tuser  = r_out_rej;

    // Magnitudes of signed operands for the unsigned multiplier.
    assign accel_mag = in_accel[23] ? 24'(-in_accel) : 24'(in_accel);
    assign wheel_mag = r_wheel_sum[24] ? 25'(-r_wheel_sum) : 25'(r_wheel_sum);
    assign innov_mag = r_innov[33] ? 34'(-r_innov) : 34'(r_innov);

    // One multiplier bit per cycle while any multiplier bits remain.
    assign mul_busy = (r_mul_mp != '0);
    assign mul_run  = mul_busy && ((r_state == kvse_pkg::S_MUL_DELTA) ||
                                   (r_state == kvse_pkg::S_MUL_MEAS)  ||
                                   (r_state == kvse_pkg::S_MUL_NOISE) ||
                                   (r_state == kvse_pkg::S_MUL_CORR)  ||
                                   (r_state == kvse_pkg::S_MUL_VAR));
    assign mul_sum  = r_mul_acc + (r_mul_mp[0] ? r_mul_mc : 58'd0);

    // One quotient bit per cycle against a right-shifting divisor.
    assign div_run  = (r_state == kvse_pkg::S_DIV_DELTA) ||
                      (r_state == kvse_pkg::S_DIV_GAIN);
    assign div_ge   = ({9'd0, r_div_rem} >= r_div_den);
    assign div_diff = r_div_rem - r_div_den[55:0];

    // Prediction terms.
    assign delta_mag = $signed({10'd0, r_div_q[23:0]});
    assign delta     = r_ax_neg ? -delta_mag : delta_mag;
    assign pred      = 35'(r_speed_state) + 35'(delta);
    assign p_sum     = {1'b0, r_error_var} + {1'b0, r_process_noise};

    // Wheel measurement rounding, gain denominator and correction rounding.
    assign meas_sum = r_mul_acc[40:0] + kvse_pkg::MEAS_HALF;
    assign meas_mag = $signed({1'b0, meas_sum[40:13]});
    assign noise    = r_rej ? r_mul_acc[39:0] : {8'd0, r_meas_noise};
    assign den      = {9'd0, r_p} + {1'b0, noise};
    assign corr_sum = r_mul_acc + kvse_pkg::GAIN_HALF;
    assign corr_mag = $signed(corr_sum[57:24]);
    assign var_sum  = r_mul_acc + kvse_pkg::GAIN_HALF;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_radius  <= kvse_pkg::RST_WHEEL_RADIUS;
            r_process_noise <= kvse_pkg::RST_PROCESS_NOISE;
            r_meas_noise    <= kvse_pkg::RST_MEASUREMENT_NOISE;
            r_reject_thr    <= kvse_pkg::RST_REJECT_THRESHOLD;
            r_reject_factor <= kvse_pkg::RST_REJECT_FACTOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kvse_pkg::CFG_WHEEL_RADIUS:      r_wheel_radius  <= i_cfg_data[15:0];
                kvse_pkg::CFG_PROCESS_NOISE:     r_process_noise <= i_cfg_data;
                kvse_pkg::CFG_MEASUREMENT_NOISE: r_meas_noise    <= i_cfg_data;
                kvse_pkg::CFG_REJECT_THRESHOLD:  r_reject_thr    <= i_cfg_data;
                kvse_pkg::CFG_REJECT_FACTOR:     r_reject_factor <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Control state and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= kvse_pkg::S_IDLE;
            r_out_valid   <= 1'b0;
            r_speed_state <= '0;
            r_error_var   <= kvse_pkg::RST_ERROR_VARIANCE;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_speed_state <= n_speed_state;
            r_error_var   <= n_error_var;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_wheel_sum <= n_wheel_sum;
        r_ax_neg    <= n_ax_neg;
        r_vp        <= n_vp;
        r_p         <= n_p;
        r_meas      <= n_meas;
        r_innov     <= n_innov;
        r_corr      <= n_corr;
        r_rej       <= n_rej;
        r_mul_acc   <= n_mul_acc;
        r_mul_mc    <= n_mul_mc;
        r_mul_mp    <= n_mul_mp;
        r_div_rem   <= n_div_rem;
        r_div_den   <= n_div_den;
        r_div_q     <= n_div_q;
        r_div_cnt   <= n_div_cnt;
        r_out_speed <= n_out_speed;
        r_out_rej   <= n_out_rej;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state       = r_state;
        n_speed_state = r_speed_state;
        n_error_var   = r_error_var;
        n_wheel_sum   = r_wheel_sum;
        n_ax_neg      = r_ax_neg;
        n_vp          = r_vp;
        n_p           = r_p;
        n_meas        = r_meas;
        n_innov       = r_innov;
        n_corr        = r_corr;
        n_rej         = r_rej;
        n_mul_acc     = r_mul_acc;
        n_mul_mc      = r_mul_mc;
        n_mul_mp      = r_mul_mp;
        n_div_rem     = r_div_rem;
        n_div_den     = r_div_den;
        n_div_q       = r_div_q;
        n_div_cnt     = r_div_cnt;
        n_out_valid   = r_out_valid;
        n_out_speed   = r_out_speed;
        n_out_rej     = r_out_rej;

        // A result leaves on a completed output transfer.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // Multiplier step.
        if (mul_run) begin
            n_mul_acc = mul_sum;
            n_mul_mc  = {r_mul_mc[56:0], 1'b0};
            n_mul_mp  = {1'b0, r_mul_mp[24:1]};
        end

        // Divider step.
        if (div_run) begin
            n_div_rem = div_ge ? div_diff : r_div_rem;
            n_div_q   = {r_div_q[23:0], div_ge};
            n_div_den = {1'b0, r_div_den[64:1]};
            n_div_cnt = r_div_cnt - 5'd1;
        end

        case (r_state)
            kvse_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_wheel_sum = 25'(in_front_left) + 25'(in_front_right);
                    n_ax_neg    = in_accel[23];
                    n_rej       = 1'b0;
                    n_mul_acc   = '0;
                    n_mul_mc    = 58'(accel_mag);
                    n_mul_mp    = 25'(in_time_step);
                    n_state     = (in_time_step == '0) ? kvse_pkg::S_DONE
                                                       : kvse_pkg::S_MUL_DELTA;
                end
            end
            kvse_pkg::S_MUL_DELTA: begin
                // Scale to seconds, rounded to nearest.
                if (!mul_busy) begin
                    n_div_rem = 56'(r_mul_acc[43:0]) + 56'(kvse_pkg::HALF_MICROS);
                    n_div_den = 65'(kvse_pkg::MICROS_PER_SECOND) << 23;
                    n_div_q   = '0;
                    n_div_cnt = 5'd23;
                    n_state   = kvse_pkg::S_DIV_DELTA;
                end
            end
            kvse_pkg::S_DIV_DELTA: begin
                if (r_div_cnt == '0) begin
                    n_state = kvse_pkg::S_PREDICT;
                end
            end
            kvse_pkg::S_PREDICT: begin
                // Predicted speed and variance, then the wheel measurement product.
                n_vp      = f_sat32(pred);
                n_p       = p_sum[32] ? 32'hFFFFFFFF : p_sum[31:0];
                n_mul_acc = '0;
                n_mul_mc  = 58'(wheel_mag);
                n_mul_mp  = 25'(r_wheel_radius);
                n_state   = kvse_pkg::S_MUL_MEAS;
            end
            kvse_pkg::S_MUL_MEAS: begin
                if (!mul_busy) begin
                    n_meas  = r_wheel_sum[24] ? -meas_mag : meas_mag;
                    n_state = kvse_pkg::S_INNOV;
                end
            end
            kvse_pkg::S_INNOV: begin
                n_innov = 34'(r_meas) - 34'(r_vp);
                n_state = kvse_pkg::S_REJECT;
            end
            kvse_pkg::S_REJECT: begin
                // Inflate the measurement noise when the wheels disagree.
                if (innov_mag > {2'd0, r_reject_thr}) begin
                    n_rej     = 1'b1;
                    n_mul_acc = '0;
                    n_mul_mc  = 58'(r_meas_noise);
                    n_mul_mp  = 25'(r_reject_factor);
                    n_state   = kvse_pkg::S_MUL_NOISE;
                end else begin
                    n_state   = kvse_pkg::S_GAIN;
                end
            end
            kvse_pkg::S_MUL_NOISE: begin
                if (!mul_busy) begin
                    n_state = kvse_pkg::S_GAIN;
                end
            end
            kvse_pkg::S_GAIN: begin
                // With no variance at all the prediction stands uncorrected.
                if (den == '0) begin
                    n_speed_state = r_vp;
                    n_error_var   = '0;
                    n_state       = kvse_pkg::S_DONE;
                end else begin
                    n_div_rem = {r_p, 24'd0};
                    n_div_den = {den, 24'd0};
                    n_div_q   = '0;
                    n_div_cnt = 5'd24;
                    n_state   = kvse_pkg::S_DIV_GAIN;
                end
            end
            kvse_pkg::S_DIV_GAIN: begin
                if (r_div_cnt == '0) begin
                    n_state = kvse_pkg::S_CORR_START;
                end
            end
            kvse_pkg::S_CORR_START: begin
                n_mul_acc = '0;
                n_mul_mc  = 58'(innov_mag);
                n_mul_mp  = r_div_q;
                n_state   = kvse_pkg::S_MUL_CORR;
            end
            kvse_pkg::S_MUL_CORR: begin
                if (!mul_busy) begin
                    n_corr  = r_innov[33] ? -corr_mag : corr_mag;
                    n_state = kvse_pkg::S_SPEED;
                end
            end
            kvse_pkg::S_SPEED: begin
                // Corrected estimate, then the variance product.
                n_speed_state = f_sat32(35'(r_vp) + 35'(r_corr));
                n_mul_acc     = '0;
                n_mul_mc      = 58'(r_p);
                n_mul_mp      = kvse_pkg::GAIN_ONE - r_div_q;
                n_state       = kvse_pkg::S_MUL_VAR;
            end
            kvse_pkg::S_MUL_VAR: begin
                if (!mul_busy) begin
                    n_error_var = var_sum[55:24];
                    n_state     = kvse_pkg::S_DONE;
                end
            end
            kvse_pkg::S_DONE: begin
                // Load the output register once it is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_speed = r_speed_state;
                    n_out_rej   = r_rej;
                    n_state     = kvse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvse_pkg::S_IDLE;
            end
        endcase
    end

    // The updated variance never exceeds the predicted variance.
    a_var_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvse_pkg::S_MUL_VAR && !mul_busy) |=> (r_error_var <= $past(r_p)))
        else $error("variance update exceeds predicted variance");

    // The gain never exceeds one.
    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvse_pkg::S_CORR_START) |-> (r_div_q <= kvse_pkg::GAIN_ONE))
        else $error("gain above one");

    // The gain division never runs against a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvse_pkg::S_DIV_GAIN) |-> (r_div_den != '0))
        else $error("gain division with zero divisor");

    // A zero time step leaves the filter state alone.
    a_zero_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_time_step == '0) |=>
            ($stable(r_speed_state) && $stable(r_error_var) && r_state == kvse_pkg::S_DONE))
        else $error("zero time step changed the state");

    // A waiting result is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvse_pkg::S_DONE && r_out_valid && !i_m_axis_tready) |=>
            (r_state == kvse_pkg::S_DONE && $stable(r_out_speed)))
        else $error("result overwritten before transfer");

endmodule
